@@ rtl/core/qtpd_pkg.sv @@
// Package for the transport-parameter decoder: codes, event record, limits.
// No dependencies.
`default_nettype none
package qtpd_pkg;
	localparam int MaxCidBytesDefault      = 20;
	localparam int MaxOtherVersionsDefault = 8;

	typedef enum logic [2:0] {
		EV_INT     = 3'd0,
		EV_CID     = 3'd1,
		EV_CID_NIL = 3'd2,
		EV_VER     = 3'd3,
		EV_NOMIG   = 3'd4,
		EV_END     = 3'd5
	} event_t;

	localparam logic [3:0] PC_ODCID   = 4'd0;
	localparam logic [3:0] PC_MIGR    = 4'd7;
	localparam logic [3:0] PC_ISCID   = 4'd8;
	localparam logic [3:0] PC_RCID    = 4'd9;
	localparam logic [3:0] PC_VERS    = 4'd10;
	localparam logic [3:0] PC_UNKNOWN = 4'd15;

	typedef struct packed {
		event_t      ev;
		logic [3:0]  code;
		logic [61:0] value;
		logic [4:0]  idx;
		logic        lov;
		logic        status;
		logic        lor;
	} result_t;

	// Parameter id to code.
	function automatic logic [3:0] map_id(input logic [63:0] id);
		logic [3:0] c;
		c = PC_UNKNOWN;
		unique case (id)
			64'h00:  c = 4'd0;
			64'h01:  c = 4'd1;
			64'h03:  c = 4'd2;
			64'h04:  c = 4'd3;
			64'h05:  c = 4'd4;
			64'h06:  c = 4'd5;
			64'h08:  c = 4'd6;
			64'h0c:  c = 4'd7;
			64'h0f:  c = 4'd8;
			64'h10:  c = 4'd9;
			64'h11:  c = 4'd10;
			default: c = PC_UNKNOWN;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/qtpd_front.sv @@
// Front end: parses bytes and produces up to two result records per beat.
// Depends on qtpd_pkg.
`default_nettype none
module qtpd_front #(
	parameter int MAX_CID_BYTES      = qtpd_pkg::MaxCidBytesDefault,
	parameter int MAX_OTHER_VERSIONS = qtpd_pkg::MaxOtherVersionsDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              has_byte,
	input  wire logic              last_item,
	output qtpd_pkg::result_t      res0,
	output qtpd_pkg::result_t      res1,
	output logic [1:0]             res_cnt
);
	import qtpd_pkg::*;

	typedef enum logic [6:0] {
		PH_ID   = 7'b0000001,
		PH_LEN  = 7'b0000010,
		PH_INT  = 7'b0000100,
		PH_CID  = 7'b0001000,
		PH_VER  = 7'b0010000,
		PH_SKIP = 7'b0100000,
		PH_ERR  = 7'b1000000
	} phase_t;

	phase_t      phase_q, ph_n;
	logic [3:0]  vleft_q, vleft_n;
	logic [63:0] vacc_q, vacc_n;
	logic [3:0]  cur_q, cur_n;
	logic [61:0] bleft_q, bleft_n;
	logic [4:0]  eidx_q, eidx_n;
	logic [31:0] wacc_q, wacc_n;
	logic        scid_q, scid_n;
	logic        err_q, err_n;

	logic [3:0]  vt_left;
	logic [63:0] vt_acc;
	logic [61:0] bdec;
	logic [3:0]  first_sz;
	logic        ver_bad;
	result_t     ev, endr;
	logic        ev_v;

	// Varint step on the incoming byte
	always_comb begin
		if (vleft_q == 4'd0) begin
			vt_acc  = {58'd0, data_byte[5:0]};
			vt_left = (4'd1 << data_byte[7:6]) - 4'd1;
		end else begin
			vt_acc  = {vacc_q[55:0], data_byte};
			vt_left = vleft_q - 4'd1;
		end
	end

	assign first_sz = 4'd1 << data_byte[7:6];
	assign bdec     = bleft_q - 62'd1;
	assign ver_bad  = (vt_acc[61:0] < 62'd4) || (vt_acc[1:0] != 2'd0) ||
		((vt_acc[63:2] - 62'd1) > 62'(MAX_OTHER_VERSIONS));

	// Byte handling
	always_comb begin
		ph_n = phase_q; vleft_n = vleft_q; vacc_n = vacc_q; cur_n = cur_q;
		bleft_n = bleft_q; eidx_n = eidx_q; wacc_n = wacc_q;
		scid_n = scid_q; err_n = err_q;
		ev = '0; ev_v = 1'b0;
		ev.code = cur_q; ev.lov = 1'b1;
		if (has_byte) begin
			unique case (phase_q)
				PH_ID: begin
					vleft_n = vt_left; vacc_n = vt_acc;
					if (vt_left == 4'd0) begin
						cur_n = map_id(vt_acc);
						ph_n  = PH_LEN;
					end
				end
				PH_LEN: begin
					vleft_n = vt_left; vacc_n = vt_acc;
					if (vt_left == 4'd0) begin
						bleft_n = vt_acc[61:0]; eidx_n = '0; wacc_n = '0;
						ph_n = PH_ID;
						if (cur_q == PC_MIGR) begin
							if (vt_acc != 64'd0) begin
								err_n = 1'b1; ph_n = PH_ERR;
							end else begin
								ev_v = 1'b1; ev.ev = EV_NOMIG;
							end
						end else if (cur_q == PC_ODCID || cur_q == PC_ISCID ||
							cur_q == PC_RCID) begin
							if (vt_acc > 64'(MAX_CID_BYTES)) begin
								err_n = 1'b1; ph_n = PH_ERR;
							end else begin
								if (cur_q == PC_ISCID) scid_n = (vt_acc != 64'd0);
								if (vt_acc == 64'd0) begin
									ev_v = 1'b1; ev.ev = EV_CID_NIL;
								end else begin
									ph_n = PH_CID;
								end
							end
						end else if (cur_q == PC_VERS) begin
							if (ver_bad) begin
								err_n = 1'b1; ph_n = PH_ERR;
							end else begin
								ph_n = PH_VER;
							end
						end else if (cur_q == PC_UNKNOWN) begin
							if (vt_acc != 64'd0) ph_n = PH_SKIP;
						end else begin
							if (vt_acc == 64'd0) begin
								err_n = 1'b1; ph_n = PH_ERR;
							end else begin
								ph_n = PH_INT;
							end
						end
					end
				end
				PH_INT: begin
					if (vleft_q == 4'd0 && {58'd0, first_sz} != bleft_q) begin
						err_n = 1'b1; ph_n = PH_ERR;
					end else begin
						vleft_n = vt_left; vacc_n = vt_acc;
						if (vt_left == 4'd0) begin
							ev_v = 1'b1; ev.ev = EV_INT; ev.value = vt_acc[61:0];
							ph_n = PH_ID;
						end
					end
				end
				PH_CID: begin
					bleft_n = bdec;
					ev_v = 1'b1; ev.ev = EV_CID; ev.value = {54'd0, data_byte};
					ev.idx = eidx_q; ev.lov = (bdec == 62'd0);
					eidx_n = eidx_q + 5'd1;
					if (bdec == 62'd0) ph_n = PH_ID;
				end
				PH_VER: begin
					wacc_n = {wacc_q[23:0], data_byte};
					bleft_n = bdec;
					if (bdec[1:0] == 2'd0) begin
						if ({wacc_q[23:0], data_byte} == 32'd0) begin
							err_n = 1'b1; ph_n = PH_ERR;
						end else begin
							ev_v = 1'b1; ev.ev = EV_VER;
							ev.value = {30'd0, wacc_q[23:0], data_byte};
							ev.idx = eidx_q; ev.lov = (bdec == 62'd0);
							eidx_n = eidx_q + 5'd1; wacc_n = '0;
							if (bdec == 62'd0) ph_n = PH_ID;
						end
					end
				end
				PH_SKIP: begin
					bleft_n = bdec;
					if (bdec == 62'd0) ph_n = PH_ID;
				end
				PH_ERR: begin
				end
				default: begin
				end
			endcase
		end
		// End status from the updated state
		endr = '0;
		endr.ev = EV_END; endr.lor = 1'b1;
		endr.status = err_n || !(ph_n == PH_ID && vleft_n == 4'd0) || !scid_n;
	end

	// Pack the results
	always_comb begin
		res0 = ev; res1 = endr; res_cnt = 2'd0;
		if (ev_v && last_item) begin
			res_cnt = 2'd2;
		end else if (ev_v) begin
			res0.lor = 1'b1; res_cnt = 2'd1;
		end else if (last_item) begin
			res0 = endr; res_cnt = 2'd1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID; vleft_q <= '0; vacc_q <= '0; cur_q <= '0;
			bleft_q <= '0; eidx_q <= '0; wacc_q <= '0; scid_q <= 1'b0;
			err_q <= 1'b0;
		end else if (in_fire) begin
			if (last_item) begin
				phase_q <= PH_ID; vleft_q <= '0; vacc_q <= '0; cur_q <= '0;
				bleft_q <= '0; eidx_q <= '0; wacc_q <= '0; scid_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				phase_q <= ph_n; vleft_q <= vleft_n; vacc_q <= vacc_n;
				cur_q <= cur_n; bleft_q <= bleft_n; eidx_q <= eidx_n;
				wacc_q <= wacc_n; scid_q <= scid_n; err_q <= err_n;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/qtpd_back.sv @@
// Back end: queue of result records; drains one per beat while out_stall is low.
// Depends on qtpd_pkg.
`default_nettype none
module qtpd_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire qtpd_pkg::result_t res0,
	input  wire qtpd_pkg::result_t res1,
	input  wire logic [1:0]   res_cnt,
	input  wire logic         in_fire,
	output logic              room,
	output logic              out_valid,
	input  wire logic         out_stall,
	output qtpd_pkg::result_t out_res
);
	import qtpd_pkg::*;

	localparam int Depth = 4;

	result_t    mem_q [Depth];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [2:0] push_n;

	assign room      = (cnt_q <= 3'd2);
	assign out_valid = (cnt_q != 3'd0);
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && !out_stall;
	assign push_n    = in_fire ? {1'b0, res_cnt} : 3'd0;

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push_n[1:0];
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + push_n - {2'd0, pop};
		end
	end

	// Entry writes
	always_ff @(posedge clk) begin
		if (in_fire && res_cnt != 2'd0) mem_q[wp_q] <= res0;
		if (in_fire && res_cnt == 2'd2) mem_q[wp_q + 2'd1] <= res1;
	end
endmodule
`default_nettype wire

@@ rtl/core/quic_transport_param_decoder_unit.sv @@
// Top level of the transport-parameter decoder: front parser plus result queue.
// Depends on qtpd_pkg, qtpd_front, qtpd_back.
`default_nettype none
// Takes one byte per cycle, back to back; each beat yields zero, one or two
// results, queued in a four-entry buffer that drains one per cycle while
// out_stall is low. Input stalls only when fewer than two entries are free.
module quic_transport_param_decoder_unit #(
	parameter int MAX_CID_BYTES      = qtpd_pkg::MaxCidBytesDefault,
	parameter int MAX_OTHER_VERSIONS = qtpd_pkg::MaxOtherVersionsDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         has_byte,
	input  wire logic         last_item,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [2:0]        event_res,
	output logic [3:0]        param_code,
	output logic [61:0]       value,
	output logic [4:0]        index,
	output logic              last_of_value,
	output logic              status,
	output logic              last_of_run
);
	import qtpd_pkg::*;

	result_t    r0, r1, orr;
	logic [1:0] rc;
	logic       room, fire;

	assign in_stall = !room;
	assign fire     = in_valid && room;

	qtpd_front #(.MAX_CID_BYTES(MAX_CID_BYTES), .MAX_OTHER_VERSIONS(MAX_OTHER_VERSIONS))
	u_front (.clk, .arst_n, .in_fire(fire), .data_byte, .has_byte, .last_item,
		.res0(r0), .res1(r1), .res_cnt(rc));

	qtpd_back u_back (.clk, .arst_n, .res0(r0), .res1(r1), .res_cnt(rc),
		.in_fire(fire), .room, .out_valid, .out_stall, .out_res(orr));

	assign event_res     = orr.ev;
	assign param_code    = orr.code;
	assign value         = orr.value;
	assign index         = orr.idx;
	assign last_of_value = orr.lov;
	assign status        = orr.status;
	assign last_of_run   = orr.lor;
endmodule
`default_nettype wire
